// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check that a property holds at every rising clock edge outside reset.
`define VLQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("vlq assertion failed");
// Check that a condition never holds outside reset.
`define VLQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("vlq forbidden condition seen");
`else
`define VLQ_ASSERT(lbl, clk, rstn, prop)
`define VLQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/core/vlq_pkg.sv =====
`default_nettype none

package vlq_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned GroupW  = 7;
  localparam int unsigned NumGrp  = 5;
  localparam int unsigned ExtW    = GroupW * NumGrp;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 3;
  localparam int unsigned MoreBit = 7;

  typedef logic [WordW-1:0] word_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Byte count under the unsigned rules: smallest length that holds the value.
  function automatic cnt_t unsigned_len(input word_t v);
    cnt_t n;
    if (v[31:7] == '0) begin
      n = 3'd1;
    end else if (v[31:14] == '0) begin
      n = 3'd2;
    end else if (v[31:21] == '0) begin
      n = 3'd3;
    end else if (v[31:28] == '0) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

  // Byte count under the signed rules: all bits above the first group's top
  // bit must be copies of the sign.
  function automatic cnt_t signed_len(input word_t v);
    cnt_t n;
    if ((&v[31:6]) || !(|v[31:6])) begin
      n = 3'd1;
    end else if ((&v[31:13]) || !(|v[31:13])) begin
      n = 3'd2;
    end else if ((&v[31:20]) || !(|v[31:20])) begin
      n = 3'd3;
    end else if ((&v[31:27]) || !(|v[31:27])) begin
      n = 3'd4;
    end else begin
      n = 3'd5;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vlq_in_if.sv =====
`default_nettype none

interface vlq_in_if;
  logic                valid;
  logic                ready;
  vlq_pkg::word_t      value_word;
  logic                is_signed;

  modport source (output valid, output value_word, output is_signed, input ready);
  modport sink   (input valid, input value_word, input is_signed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vlq_out_if.sv =====
`default_nettype none

interface vlq_out_if;
  logic           valid;
  logic           ready;
  vlq_pkg::byte_t out_byte;
  logic           last_byte;

  modport source (output valid, output out_byte, output last_byte, input ready);
  modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/vlq_integer_encoder_core.sv =====
// The first byte of an item is valid once the item has passed the input register
// and been loaded into the output byte register; it leaves when out_o.ready is high.
// The output gives one byte per cycle while out_o.ready is high; an item is one to
// five bytes, equal to its encoded length.
// The input register takes the next item while the current one is still emitting.
// Reset (rst_ni low, asynchronous) empties both stages; data registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module vlq_integer_encoder_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  vlq_in_if.sink       in_i,
  vlq_out_if.source    out_o
);

  // Input stage: sign- or zero-extended word and byte count
  logic                        a_valid_q;
  logic [vlq_pkg::ExtW-1:0]    a_x_q;
  vlq_pkg::cnt_t               a_cnt_q;

  // Emit stage: word being sent and bytes still to send
  logic                        b_valid_q;
  logic [vlq_pkg::ExtW-1:0]    b_x_q;
  vlq_pkg::cnt_t               b_cnt_q;

  logic                        in_fire;
  logic                        b_fire;
  logic                        b_done;
  logic                        b_load;
  logic [vlq_pkg::ExtW-1:0]    x_ext;
  vlq_pkg::cnt_t               len;
  logic [vlq_pkg::GroupW-1:0]  grp;
  logic                        is_last;

  // Handshake decode
  assign b_fire  = b_valid_q && out_o.ready;
  assign b_done  = b_fire && (b_cnt_q == 3'd1);
  assign b_load  = a_valid_q && (!b_valid_q || b_done);
  assign in_i.ready = !a_valid_q || b_load;
  assign in_fire = in_i.valid && in_i.ready;

  // Extend to five groups and pick the length
  always_comb begin
    x_ext = {{(vlq_pkg::ExtW - vlq_pkg::WordW){in_i.is_signed && in_i.value_word[31]}},
             in_i.value_word};
    len   = in_i.is_signed ? vlq_pkg::signed_len(in_i.value_word)
                           : vlq_pkg::unsigned_len(in_i.value_word);
  end

  // Hold the accepted item until the emit stage frees up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (b_load) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_x_q   <= x_ext;
      a_cnt_q <= len;
    end
  end

  // Load a new item or advance to the next byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_load) begin
      b_valid_q <= 1'b1;
    end else if (b_done) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_load) begin
      b_x_q   <= a_x_q;
      b_cnt_q <= a_cnt_q;
    end else if (b_fire) begin
      b_cnt_q <= b_cnt_q - 3'd1;
    end
  end

  // Select the current group, most significant first
  always_comb begin
    case (b_cnt_q)
      3'd5:    grp = b_x_q[4*vlq_pkg::GroupW +: vlq_pkg::GroupW];
      3'd4:    grp = b_x_q[3*vlq_pkg::GroupW +: vlq_pkg::GroupW];
      3'd3:    grp = b_x_q[2*vlq_pkg::GroupW +: vlq_pkg::GroupW];
      3'd2:    grp = b_x_q[1*vlq_pkg::GroupW +: vlq_pkg::GroupW];
      default: grp = b_x_q[0 +: vlq_pkg::GroupW];
    endcase
    is_last = (b_cnt_q == 3'd1);
  end

  assign out_o.valid     = b_valid_q;
  assign out_o.out_byte  = {!is_last, grp};
  assign out_o.last_byte = is_last;

  // Checks
  `VLQ_ASSERT(cnt_range_a, clk_i, rst_ni,
    b_valid_q |-> (b_cnt_q != 3'd0) && (b_cnt_q <= 3'd5))
  `VLQ_ASSERT(more_flag_a, clk_i, rst_ni,
    b_valid_q |-> (out_o.out_byte[vlq_pkg::MoreBit] == !out_o.last_byte))
  `VLQ_ASSERT(drain_a, clk_i, rst_ni,
    (b_done && !a_valid_q) |=> !b_valid_q)
  `VLQ_ASSERT_NEVER(overrun_a, clk_i, rst_ni,
    a_valid_q && !b_load && in_i.ready)

endmodule

`default_nettype wire
